>>> rtl/glb_cdf_pkg.sv
// Package for the GLB container deframer: state, result and phase types,
// byte-kind and status codes, and the container constants.
// No dependencies; used by every module of the block.
package glb_cdf_pkg;

   localparam logic [31:0] MAGIC_WORD    = 32'h4654_6C67;  // "glTF", little-endian
   localparam logic [31:0] TYPE_JSON     = 32'h4E4F_534A;
   localparam logic [31:0] TYPE_BIN      = 32'h004E_4942;
   localparam logic [31:0] MIN_STREAM    = 32'd20;
   localparam logic [31:0] FILE_HDR_LEN  = 32'd12;
   localparam logic [32:0] ALIGN_MASK    = ~33'd3;

   localparam logic [2:0] KIND_HEADER = 3'd0;
   localparam logic [2:0] KIND_JSON   = 3'd1;
   localparam logic [2:0] KIND_BIN    = 3'd2;
   localparam logic [2:0] KIND_OTHER  = 3'd3;
   localparam logic [2:0] KIND_IGNORE = 3'd4;

   localparam logic [2:0] STAT_RUNNING   = 3'd0;
   localparam logic [2:0] STAT_OK        = 3'd1;
   localparam logic [2:0] STAT_BAD_MAGIC = 3'd2;
   localparam logic [2:0] STAT_OVERRUN   = 3'd3;
   localparam logic [2:0] STAT_TRUNCATED = 3'd4;
   localparam logic [2:0] STAT_NO_JSON   = 3'd5;

   typedef enum logic [5:0] {
      PH_FILEHDR  = 6'b000001,
      PH_CHUNKHDR = 6'b000010,
      PH_PAYLOAD  = 6'b000100,
      PH_PAD      = 6'b001000,
      PH_IGNORE   = 6'b010000,
      PH_ERROR    = 6'b100000
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] byte_offset;
      logic [31:0] header_shift;
      logic [31:0] declared_total;
      logic [31:0] chunk_length;
      logic [31:0] chunk_type;
      logic [32:0] chunk_end;
      logic [32:0] payload_start;
      logic        json_seen;
      logic [2:0]  error_code;
   } state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] byte_kind;
      logic       chunk_start;
      logic       done_res;
      logic [2:0] status;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:          PH_FILEHDR,
      byte_offset:    32'd0,
      header_shift:   32'd0,
      declared_total: 32'd0,
      chunk_length:   32'd0,
      chunk_type:     32'd0,
      chunk_end:      33'd0,
      payload_start:  33'd0,
      json_seen:      1'b0,
      error_code:     STAT_RUNNING
   };

endpackage

>>> rtl/glb_cdf_step.sv
// Per-word step logic of the GLB deframer: next parser state and the tagged result.
// Purely combinational; depends on glb_cdf_pkg.
module glb_cdf_step (
   input  glb_cdf_pkg::state_type  cur_state,
   input  logic [7:0]              in_byte,
   input  logic                    in_last,
   output glb_cdf_pkg::state_type  next_state,
   output glb_cdf_pkg::result_type result
);

   // A chunk header starting at next_pos is read only if it fits in the declared length.
   function automatic logic region_fits(input logic [32:0] next_pos,
                                        input logic [31:0] total);
      region_fits = ({1'b0, next_pos} + 34'd8) <= {2'b00, total};
   endfunction

   logic [32:0] pos;
   logic [31:0] shift_new;
   logic [32:0] rel;
   logic [32:0] end_new;
   logic [32:0] pad_aligned;
   logic [1:0]  magic_idx;
   glb_cdf_pkg::state_type nx;
   logic [2:0]  kind;
   logic        start;
   logic [2:0]  status;

   always_comb begin
      pos         = {1'b0, cur_state.byte_offset};
      shift_new   = {in_byte, cur_state.header_shift[31:8]};
      rel         = pos - cur_state.chunk_end;
      end_new     = pos + 33'd1 + {1'b0, cur_state.chunk_length};
      pad_aligned = (cur_state.chunk_end + 33'd3) & glb_cdf_pkg::ALIGN_MASK;
      magic_idx   = cur_state.byte_offset[1:0];
      nx          = cur_state;
      nx.header_shift = shift_new;
      kind        = glb_cdf_pkg::KIND_IGNORE;
      start       = 1'b0;

      case (cur_state.phase)
         glb_cdf_pkg::PH_FILEHDR: begin
            kind = glb_cdf_pkg::KIND_HEADER;
            if (cur_state.byte_offset < 32'd4 &&
                in_byte != glb_cdf_pkg::MAGIC_WORD[8*magic_idx +: 8]) begin
               nx.error_code = glb_cdf_pkg::STAT_BAD_MAGIC;
               nx.phase      = glb_cdf_pkg::PH_ERROR;
            end else if (cur_state.byte_offset == glb_cdf_pkg::FILE_HDR_LEN - 32'd1) begin
               nx.declared_total = shift_new;
               if (region_fits({1'b0, glb_cdf_pkg::FILE_HDR_LEN}, shift_new)) begin
                  nx.phase     = glb_cdf_pkg::PH_CHUNKHDR;
                  nx.chunk_end = {1'b0, glb_cdf_pkg::FILE_HDR_LEN};
               end else begin
                  nx.phase = glb_cdf_pkg::PH_IGNORE;
               end
            end
         end
         glb_cdf_pkg::PH_CHUNKHDR: begin
            kind = glb_cdf_pkg::KIND_HEADER;
            if (rel == 33'd3) begin
               nx.chunk_length = shift_new;
            end else if (rel == 33'd7) begin
               nx.chunk_type    = shift_new;
               nx.chunk_end     = end_new;
               nx.payload_start = pos + 33'd1;
               if (end_new > {1'b0, cur_state.declared_total}) begin
                  nx.error_code = glb_cdf_pkg::STAT_OVERRUN;
                  nx.phase      = glb_cdf_pkg::PH_ERROR;
               end else begin
                  if (shift_new == glb_cdf_pkg::TYPE_JSON) begin
                     nx.json_seen = (cur_state.chunk_length != 32'd0);
                  end
                  if (cur_state.chunk_length != 32'd0) begin
                     nx.phase = glb_cdf_pkg::PH_PAYLOAD;
                  end else if (end_new[1:0] != 2'b00) begin
                     nx.phase = glb_cdf_pkg::PH_PAD;
                  end else if (region_fits(end_new, cur_state.declared_total)) begin
                     nx.phase = glb_cdf_pkg::PH_CHUNKHDR;
                  end else begin
                     nx.phase = glb_cdf_pkg::PH_IGNORE;
                  end
               end
            end
         end
         glb_cdf_pkg::PH_PAYLOAD: begin
            if (cur_state.chunk_type == glb_cdf_pkg::TYPE_JSON) begin
               kind = glb_cdf_pkg::KIND_JSON;
            end else if (cur_state.chunk_type == glb_cdf_pkg::TYPE_BIN) begin
               kind = glb_cdf_pkg::KIND_BIN;
            end else begin
               kind = glb_cdf_pkg::KIND_OTHER;
            end
            start = (pos == cur_state.payload_start);
            if (pos + 33'd1 >= cur_state.chunk_end) begin
               // The chunk_end register already holds the next header start.
               if (cur_state.chunk_end[1:0] != 2'b00) begin
                  nx.phase = glb_cdf_pkg::PH_PAD;
               end else if (region_fits(cur_state.chunk_end, cur_state.declared_total)) begin
                  nx.phase = glb_cdf_pkg::PH_CHUNKHDR;
               end else begin
                  nx.phase = glb_cdf_pkg::PH_IGNORE;
               end
            end
         end
         glb_cdf_pkg::PH_PAD: begin
            if (pos + 33'd1 >= pad_aligned) begin
               if (region_fits(pad_aligned, cur_state.declared_total)) begin
                  nx.phase     = glb_cdf_pkg::PH_CHUNKHDR;
                  nx.chunk_end = pad_aligned;
               end else begin
                  nx.phase = glb_cdf_pkg::PH_IGNORE;
               end
            end
         end
         default: begin
         end
      endcase

      if (cur_state.byte_offset != 32'hFFFF_FFFF) begin
         nx.byte_offset = cur_state.byte_offset + 32'd1;
      end

      status = glb_cdf_pkg::STAT_RUNNING;
      if (in_last) begin
         if (nx.byte_offset < glb_cdf_pkg::MIN_STREAM) begin
            status = glb_cdf_pkg::STAT_TRUNCATED;
         end else if (nx.error_code != glb_cdf_pkg::STAT_RUNNING) begin
            status = nx.error_code;
         end else if (nx.phase == glb_cdf_pkg::PH_PAYLOAD) begin
            status = glb_cdf_pkg::STAT_TRUNCATED;
         end else if (!nx.json_seen) begin
            status = glb_cdf_pkg::STAT_NO_JSON;
         end else begin
            status = glb_cdf_pkg::STAT_OK;
         end
      end

      // The last word of a stream returns the parser to its reset state.
      next_state = in_last ? glb_cdf_pkg::STATE_RESET : nx;

      result.out_byte    = in_byte;
      result.byte_kind   = kind;
      result.chunk_start = start;
      result.done_res    = in_last;
      result.status      = status;
   end

endmodule

>>> rtl/glb_container_deframer_core.sv
// Top level of the GLB container deframer: input register, parser state and
// result register around the step logic. Depends on glb_cdf_pkg and glb_cdf_step.
//
// Usage: a binary glTF container enters one byte per word on the req_ channel
// (req_in_byte, req_in_last marks the final byte of a stream). Every word yields
// exactly one result word on the rsp_ channel: the byte itself, its kind (header,
// JSON, BIN, other payload, or ignored, also used for padding), a chunk_start
// flag on the first payload byte of each non-empty chunk, and on the final byte
// done_res with the stream status. After the final byte the parser is back in
// its reset state, so the next word starts a new container.
// Throughput is one word per cycle while rsp_stall is low: the parser state is
// updated once per word by counter and compare logic between the input register
// and the result register. An accepted word sits in the input register first,
// and is then tagged into the result register.
// When the receiver raises rsp_stall the result register holds its word; the
// input register keeps filling, and req_stall rises only once both hold a word.
// Reset (synchronous) empties both registers and clears the parser state.
module glb_container_deframer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_byte_kind,
   output logic       rsp_chunk_start,
   output logic       rsp_done_res,
   output logic [2:0] rsp_status
);

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;
   logic                   rsp_valid_ff;
   glb_cdf_pkg::result_type rsp_ff;
   glb_cdf_pkg::state_type state_ff;
   glb_cdf_pkg::state_type state_in;
   glb_cdf_pkg::result_type result_in;
   logic                   out_free;
   logic                   step_go;
   logic                   req_take;

   // The result register can take a new word when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_go   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   glb_cdf_step u_step (
      .cur_state  (state_ff),
      .in_byte    (in_byte_ff),
      .in_last    (in_last_ff),
      .next_state (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (step_go) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= glb_cdf_pkg::STATE_RESET;
      end else if (step_go) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_ff.out_byte;
   assign rsp_byte_kind   = rsp_ff.byte_kind;
   assign rsp_chunk_start = rsp_ff.chunk_start;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_status      = rsp_ff.status;

endmodule

>>> rtl/glb_cdf_checker.sv
// Port-level checks for the GLB container deframer, bound to its top level.
// Depends on glb_cdf_pkg and glb_container_deframer_core.
module glb_cdf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [2:0] rsp_byte_kind,
   input logic       rsp_chunk_start,
   input logic       rsp_done_res,
   input logic [2:0] rsp_status
);

   // A status is reported on the final byte of a stream and only there.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == glb_cdf_pkg::STAT_RUNNING)
      else $error("status reported before the final byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_status != glb_cdf_pkg::STAT_RUNNING)
      else $error("final byte carries no status");

   // Chunk starts are flagged only on payload bytes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chunk_start |->
         (rsp_byte_kind == glb_cdf_pkg::KIND_JSON || rsp_byte_kind == glb_cdf_pkg::KIND_BIN ||
          rsp_byte_kind == glb_cdf_pkg::KIND_OTHER))
      else $error("chunk start on a non-payload byte");

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_byte_kind) && $stable(rsp_status) && $stable(rsp_done_res))
      else $error("stalled result word changed");

endmodule

bind glb_container_deframer_core glb_cdf_checker u_glb_cdf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_byte_kind   (rsp_byte_kind),
   .rsp_chunk_start (rsp_chunk_start),
   .rsp_done_res    (rsp_done_res),
   .rsp_status      (rsp_status)
);
